/* rtl/core/ldp_pkg.sv */
// shared types, codes and helpers for the landing descent profile core
package ldp_pkg;

  localparam int FracBits = 16;
  localparam int TimeBits = 48;
  localparam int CfgIdxBits = 3;
  localparam int DivSteps = 64;

  // request codes
  typedef enum logic [1:0] {
    REQ_SYNC     = 2'd0,
    REQ_TAKEOVER = 2'd1,
    REQ_UPDATE   = 2'd2,
    REQ_RSVD     = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TIME_BACK   = 3'd1,
    ST_POSE_BAD    = 3'd2,
    ST_INACTIVE    = 3'd3,
    ST_DISARM_FAIL = 3'd4
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DESCENT_RATE   = 3'd0,
    CFG_CUSHION_RATE   = 3'd1,
    CFG_DESCENT_ACCEL  = 3'd2,
    CFG_CUSHION_ACCEL  = 3'd3,
    CFG_LANDING_HEIGHT = 3'd4
  } cfg_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_SIMPLE   = 4'd2,
    OP_MUL_DR   = 4'd3,
    OP_DIV_T1   = 4'd4,
    OP_MUL_ZDA  = 4'd5,
    OP_DIV_T2   = 4'd6,
    OP_TAKE_FIN = 4'd7,
    OP_MUL_ACC  = 4'd8,
    OP_VEL      = 4'd9,
    OP_MUL_VEL  = 4'd10,
    OP_UPD_FIN  = 4'd11
  } op_e;

  // item classification after the checks
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_TAKE   = 2'd1,
    KIND_UPD    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [TimeBits-1:0] timestamp;
    logic                pose_valid;
    logic signed [31:0]  meas_x;
    logic signed [31:0]  meas_y;
    logic signed [31:0]  meas_z;
    logic                disarm_ack;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_vz;
    logic signed [31:0] target_az;
    logic               disarm_request;
    logic               landing_done;
  } out_t;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  div_busy;
  } stat_t;

  // saturate to the s32 range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh0000000080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // magnitude of a signed word, 2^31 fits unsigned
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

endpackage

/* rtl/core/ldp_datapath.sv */
// datapath: configuration, profile state, shared multiplier and serial divider
module ldp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ldp_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  ldp_pkg::in_t                   in_data_i,
  input  ldp_pkg::cmd_t                  cmd_i,
  output ldp_pkg::stat_t                 stat_o,
  output ldp_pkg::out_t                  out_data_o
);
  import ldp_pkg::*;

  logic signed [31:0] dr_q, cr_q, da_q, lh_q;
  logic [30:0]        ca_q;
  logic               desc_q;
  logic [TimeBits-1:0] last_q;
  logic signed [31:0] hold_x_q, hold_y_q, set_h_q, cush_q, dv_q;
  in_t                item_q;
  out_t               out_q, out_d;
  logic [63:0]        prod_q;
  logic               prod_neg_q;
  logic signed [63:0] t1_q;
  logic [32:0]        rem_q, dvs_q;
  logic [63:0]        quo_q;
  logic [6:0]         cnt_q;
  logic               busy_q;

  logic                rt_err, t_back, above, land, num_neg;
  logic [TimeBits-1:0] diff;
  logic [30:0]         dt;
  logic signed [31:0]  acc, vel_new, h_new, cush_new, az;
  logic signed [33:0]  den;
  logic [32:0]         den_mag;
  logic [31:0]         mul_a, mul_b;
  logic                mul_neg;
  logic [63:0]         prod_d;
  logic signed [63:0]  mq, v, h, t1_sel, t2;
  logic [33:0]         sh;
  logic                qbit;
  status_e             simple_st;
  kind_e               kind;

  // checks in the order of priority
  assign t_back = (item_q.req_type != REQ_SYNC) && (item_q.timestamp < last_q);
  assign rt_err = (item_q.req_type == REQ_RSVD) || t_back || !item_q.pose_valid;

  always_comb begin
    if (item_q.req_type == REQ_RSVD) simple_st = ST_INACTIVE;
    else if (t_back) simple_st = ST_TIME_BACK;
    else if (!item_q.pose_valid) simple_st = ST_POSE_BAD;
    else if (item_q.req_type == REQ_SYNC) simple_st = ST_OK;
    else simple_st = ST_INACTIVE;
    kind = KIND_SIMPLE;
    if (!rt_err && item_q.req_type == REQ_TAKEOVER) kind = KIND_TAKE;
    if (!rt_err && item_q.req_type == REQ_UPDATE && desc_q) kind = KIND_UPD;
  end

  assign stat_o.kind = kind;
  assign stat_o.div_busy = busy_q;

  // elapsed time, saturated to 31 bits
  assign diff = item_q.timestamp - last_q;
  assign dt = (|diff[TimeBits-1:31]) ? 31'h7FFFFFFF : diff[30:0];

  assign above = item_q.meas_z > cush_q;
  assign land  = item_q.meas_z <= lh_q;
  assign acc   = above ? da_q : $signed({1'b0, ca_q});

  // second cushion term denominator and sign
  assign den     = $signed({3'b000, ca_q}) - $signed({{2{da_q[31]}}, da_q});
  assign den_mag = den[33] ? 33'(-den) : den[32:0];
  assign num_neg = item_q.meas_z[31] ^ ~da_q[31];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    case (cmd_i.op)
      OP_MUL_DR: begin
        mul_a = abs32(dr_q);
        mul_b = abs32(dr_q);
      end
      OP_MUL_ZDA: begin
        mul_a = abs32(item_q.meas_z);
        mul_b = abs32(da_q);
      end
      OP_MUL_ACC: begin
        mul_a = abs32(acc);
        mul_b = {1'b0, dt};
        mul_neg = acc[31];
      end
      OP_MUL_VEL: begin
        mul_a = abs32(dv_q);
        mul_b = {1'b0, dt};
        mul_neg = dv_q[31];
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign mq = $signed(prod_neg_q ? (64'd0 - prod_q) : prod_q) >>> FracBits;

  // velocity ramp and height integration
  always_comb begin
    v = 64'(dv_q) + mq;
    if (above) begin
      if (v < 64'(dr_q)) v = 64'(dr_q);
    end else begin
      if (v > 64'(cr_q)) v = 64'(cr_q);
    end
    vel_new = sat32(v);
    h = 64'(set_h_q) + mq;
    if (h < 0) h = '0;
    h_new = sat32(h);
    if (above) az = (dv_q > dr_q) ? da_q : '0;
    else az = (dv_q < cr_q) ? $signed({1'b0, ca_q}) : '0;
  end

  // cushion height terms
  always_comb begin
    t1_sel = (ca_q == '0) ? 64'sh000000007FFFFFFF : $signed(quo_q);
    if (den == '0) t2 = '0;
    else if (num_neg ^ den[33]) t2 = -$signed(quo_q);
    else t2 = $signed(quo_q);
    cush_new = sat32((t1_q < t2) ? t1_q : t2);
  end

  // restoring division step
  assign sh   = {rem_q, quo_q[63]};
  assign qbit = sh >= {1'b0, dvs_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dr_q <= -32'sd32768;
      cr_q <= -32'sd6554;
      da_q <= -32'sd32768;
      ca_q <= 31'd65536;
      lh_q <= 32'sd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DESCENT_RATE:   dr_q <= cfg_data_i;
        CFG_CUSHION_RATE:   cr_q <= cfg_data_i;
        CFG_DESCENT_ACCEL:  da_q <= cfg_data_i;
        CFG_CUSHION_ACCEL:  ca_q <= cfg_data_i[30:0];
        CFG_LANDING_HEIGHT: lh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // profile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q   <= 1'b0;
      last_q   <= '0;
      hold_x_q <= '0;
      hold_y_q <= '0;
      set_h_q  <= '0;
      cush_q   <= '0;
      dv_q     <= '0;
    end else begin
      case (cmd_i.op)
        OP_SIMPLE: begin
          if (simple_st == ST_OK) last_q <= item_q.timestamp;
        end
        OP_TAKE_FIN: begin
          hold_x_q <= item_q.meas_x;
          hold_y_q <= item_q.meas_y;
          set_h_q  <= item_q.meas_z;
          cush_q   <= cush_new;
          dv_q     <= '0;
          desc_q   <= 1'b1;
          last_q   <= item_q.timestamp;
        end
        OP_VEL: dv_q <= vel_new;
        OP_UPD_FIN: begin
          set_h_q <= h_new;
          if (!land || item_q.disarm_ack) begin
            last_q <= item_q.timestamp;
            if (land) desc_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // serial divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.op == OP_DIV_T1 || cmd_i.op == OP_DIV_T2) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'(DivSteps - 1)) busy_q <= 1'b0;
    end
  end

  // next result contents
  always_comb begin
    out_d = out_q;
    case (cmd_i.op)
      OP_SIMPLE: begin
        out_d = '0;
        out_d.status = simple_st;
        out_d.landing_done = ~desc_q;
      end
      OP_TAKE_FIN: begin
        out_d = '0;
        out_d.status = ST_OK;
      end
      OP_UPD_FIN: begin
        out_d = '0;
        if (land && !item_q.disarm_ack) begin
          out_d.status = ST_DISARM_FAIL;
          out_d.disarm_request = 1'b1;
        end else begin
          out_d.status = ST_OK;
          out_d.target_x = hold_x_q;
          out_d.target_y = hold_y_q;
          out_d.target_z = h_new;
          out_d.target_vz = dv_q;
          out_d.target_az = az;
          out_d.disarm_request = land;
          out_d.landing_done = land;
        end
      end
      default: ;
    endcase
  end

  // item, product, divider and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) item_q <= in_data_i;
    if (cmd_i.op == OP_MUL_DR || cmd_i.op == OP_MUL_ZDA ||
        cmd_i.op == OP_MUL_ACC || cmd_i.op == OP_MUL_VEL) begin
      prod_q     <= prod_d;
      prod_neg_q <= mul_neg;
    end
    if (cmd_i.op == OP_MUL_ZDA) t1_q <= t1_sel;
    if (cmd_i.op == OP_DIV_T1) begin
      rem_q <= '0;
      quo_q <= prod_q;
      dvs_q <= {1'b0, ca_q, 1'b0};
    end else if (cmd_i.op == OP_DIV_T2) begin
      rem_q <= '0;
      quo_q <= prod_q;
      dvs_q <= den_mag;
    end else if (busy_q) begin
      rem_q <= qbit ? 33'(sh - {1'b0, dvs_q}) : sh[32:0];
      quo_q <= {quo_q[62:0], qbit};
    end
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

/* rtl/core/ldp_ctrl.sv */
// controller: sequences the datapath and owns both handshakes
module ldp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ldp_pkg::stat_t stat_i,
  output ldp_pkg::cmd_t  cmd_o
);
  import ldp_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_CHECK    = 14'b00000000000010,
    S_SIMPLE   = 14'b00000000000100,
    S_MUL_DR   = 14'b00000000001000,
    S_DIV_T1   = 14'b00000000010000,
    S_WAIT_T1  = 14'b00000000100000,
    S_MUL_ZDA  = 14'b00000001000000,
    S_DIV_T2   = 14'b00000010000000,
    S_WAIT_T2  = 14'b00000100000000,
    S_TAKE_FIN = 14'b00001000000000,
    S_MUL_ACC  = 14'b00010000000000,
    S_VEL      = 14'b00100000000000,
    S_MUL_VEL  = 14'b01000000000000,
    S_UPD_FIN  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, fin;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat_i.kind)
          KIND_TAKE: state_d = S_MUL_DR;
          KIND_UPD:  state_d = S_MUL_ACC;
          default:   state_d = S_SIMPLE;
        endcase
      end
      S_SIMPLE: begin
        if (out_free) begin
          cmd_o.op = OP_SIMPLE;
          state_d = S_IDLE;
        end
      end
      S_MUL_DR: begin
        cmd_o.op = OP_MUL_DR;
        state_d = S_DIV_T1;
      end
      S_DIV_T1: begin
        cmd_o.op = OP_DIV_T1;
        state_d = S_WAIT_T1;
      end
      S_WAIT_T1: begin
        if (!stat_i.div_busy) state_d = S_MUL_ZDA;
      end
      S_MUL_ZDA: begin
        cmd_o.op = OP_MUL_ZDA;
        state_d = S_DIV_T2;
      end
      S_DIV_T2: begin
        cmd_o.op = OP_DIV_T2;
        state_d = S_WAIT_T2;
      end
      S_WAIT_T2: begin
        if (!stat_i.div_busy) state_d = S_TAKE_FIN;
      end
      S_TAKE_FIN: begin
        if (out_free) begin
          cmd_o.op = OP_TAKE_FIN;
          state_d = S_IDLE;
        end
      end
      S_MUL_ACC: begin
        cmd_o.op = OP_MUL_ACC;
        state_d = S_VEL;
      end
      S_VEL: begin
        cmd_o.op = OP_VEL;
        state_d = S_MUL_VEL;
      end
      S_MUL_VEL: begin
        cmd_o.op = OP_MUL_VEL;
        state_d = S_UPD_FIN;
      end
      S_UPD_FIN: begin
        if (out_free) begin
          cmd_o.op = OP_UPD_FIN;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign fin = (cmd_o.op == OP_SIMPLE) || (cmd_o.op == OP_TAKE_FIN) ||
               (cmd_o.op == OP_UPD_FIN);

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (fin) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted transaction always goes to classification
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CHECK))
    else $error("accepted transaction not followed by check");

  // a result is never written over one that is still waiting
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> out_free)
    else $error("result written while output still stalled");

  // valid only rises after a finishing step
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fin))
    else $error("result valid without a finishing step");

endmodule

/* rtl/core/landing_descent_profile_core.sv */
// top level of the landing descent profile core
// a time sync or rejected transaction goes from check straight to its result; a periodic
// update runs two multiplies; a takeover runs two 64-step serial divisions
// throughput: one transaction at a time; the next is taken on returning to idle,
// while the finished result may still wait in the output register
// reset: asynchronous active low; config returns to defaults, profile state clears
module landing_descent_profile_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ldp_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ldp_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ldp_pkg::out_t                  out_data_o
);
  import ldp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ldp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  ldp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

/* tb/landing_descent_profile_core_test.sv */
// self-checking testbench for the landing descent profile core
`timescale 1ns / 100ps

module landing_descent_profile_core_test;
  import ldp_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int ItemTarget = 1450;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  landing_descent_profile_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the configuration
  logic signed [31:0] c_dr = -32'sd32768;
  logic signed [31:0] c_cr = -32'sd6554;
  logic signed [31:0] c_da = -32'sd32768;
  logic [30:0]        c_ca = 31'd65536;
  logic signed [31:0] c_lh = 32'sd6554;

  // predictor copy of the profile state
  logic               active = 1'b0;
  logic [47:0]        last_t = '0;
  logic signed [31:0] hold_x = '0, hold_y = '0, set_h = '0, cush_h = '0, vel = '0;

  out_t setpoint_q[$];
  int unsigned items_sent = 0, results_seen = 0, mismatches = 0;
  int unsigned updates_ok = 0, landings = 0, takeovers = 0;
  int unsigned idle_pct = 0, stall_pct = 0;

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] cushion_of(input logic signed [31:0] z);
    longint unsigned mag, q1;
    longint t1, t2, den;
    mag = c_dr[31] ? longint'(-longint'(c_dr)) : longint'(c_dr);
    if (c_ca == 0) t1 = 64'sh7FFFFFFF;
    else begin
      q1 = (mag * mag) / (64'd2 * longint'({1'b0, c_ca}));
      t1 = longint'(q1);
    end
    den = longint'({1'b0, c_ca}) - longint'(c_da);
    if (den == 0) t2 = 0;
    else t2 = (longint'(z) * -longint'(c_da)) / den;
    return clamp_s32(t1 < t2 ? t1 : t2);
  endfunction

  // expected setpoint for one transaction, advances the predictor state
  function automatic out_t predict_setpoint(input in_t it);
    out_t r;
    logic [47:0] dt48;
    longint dt, v, h;
    logic above;
    r = '0;
    if (it.req_type == REQ_RSVD) r.status = ST_INACTIVE;
    else if (it.req_type != REQ_SYNC && it.timestamp < last_t) r.status = ST_TIME_BACK;
    else if (!it.pose_valid) r.status = ST_POSE_BAD;
    else if (it.req_type == REQ_SYNC) last_t = it.timestamp;
    else if (it.req_type == REQ_TAKEOVER) begin
      hold_x = it.meas_x;
      hold_y = it.meas_y;
      set_h = it.meas_z;
      cush_h = cushion_of(it.meas_z);
      vel = '0;
      active = 1'b1;
      last_t = it.timestamp;
    end else if (!active) r.status = ST_INACTIVE;
    else begin
      dt48 = it.timestamp - last_t;
      dt = (dt48 > 48'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(dt48);
      above = it.meas_z > cush_h;
      v = longint'(vel);
      if (above) begin
        v += (longint'(c_da) * dt) >>> FracBits;
        if (v < longint'(c_dr)) v = longint'(c_dr);
      end else begin
        v += (longint'({1'b0, c_ca}) * dt) >>> FracBits;
        if (v > longint'(c_cr)) v = longint'(c_cr);
      end
      vel = clamp_s32(v);
      h = longint'(set_h) + ((longint'(vel) * dt) >>> FracBits);
      if (h < 0) h = 0;
      set_h = clamp_s32(h);
      if (it.meas_z <= c_lh && !it.disarm_ack) begin
        r.status = ST_DISARM_FAIL;
        r.disarm_request = 1'b1;
      end else begin
        if (it.meas_z <= c_lh) active = 1'b0;
        if (above) r.target_az = (vel > c_dr) ? c_da : '0;
        else r.target_az = (vel < c_cr) ? $signed({1'b0, c_ca}) : '0;
        last_t = it.timestamp;
        r.target_x = hold_x;
        r.target_y = hold_y;
        r.target_z = set_h;
        r.target_vz = vel;
        r.disarm_request = (it.meas_z <= c_lh);
      end
    end
    r.landing_done = !active;
    return r;
  endfunction

  // send one transaction with random sender gaps, predict on acceptance
  task automatic send_item(input in_t it);
    out_t e;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < idle_pct) in_valid_i <= 1'b0;
      else break;
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    e = predict_setpoint(it);
    setpoint_q.push_back(e);
    items_sent++;
    if (e.status == ST_OK && it.req_type == REQ_UPDATE) updates_ok++;
    if (e.status == ST_OK && it.req_type == REQ_TAKEOVER) takeovers++;
    if (e.status == ST_OK && e.disarm_request) landings++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DESCENT_RATE:   c_dr = val;
      CFG_CUSHION_RATE:   c_cr = val;
      CFG_DESCENT_ACCEL:  c_da = val;
      CFG_CUSHION_ACCEL:  c_ca = val[30:0];
      CFG_LANDING_HEIGHT: c_lh = val;
      default: ;
    endcase
  endtask

  task automatic load_profile(input logic [31:0] dr, input logic [31:0] cr,
                              input logic [31:0] da, input logic [31:0] ca,
                              input logic [31:0] lh);
    drain_results();
    write_reg(CFG_DESCENT_RATE, dr);
    write_reg(CFG_CUSHION_RATE, cr);
    write_reg(CFG_DESCENT_ACCEL, da);
    write_reg(CFG_CUSHION_ACCEL, ca);
    write_reg(CFG_LANDING_HEIGHT, lh);
  endtask

  function automatic in_t make_item(input req_e rt, input logic [47:0] ts,
                                    input logic pv, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z,
                                    input logic ack);
    in_t it;
    it.req_type = rt;
    it.timestamp = ts;
    it.pose_valid = pv;
    it.meas_x = x;
    it.meas_y = y;
    it.meas_z = z;
    it.disarm_ack = ack;
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_t e;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (setpoint_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        e = setpoint_q.pop_front();
        if (out_data_o.status !== e.status || out_data_o.target_x !== e.target_x ||
            out_data_o.target_y !== e.target_y || out_data_o.target_z !== e.target_z ||
            out_data_o.target_vz !== e.target_vz || out_data_o.target_az !== e.target_az ||
            out_data_o.disarm_request !== e.disarm_request ||
            out_data_o.landing_done !== e.landing_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                     results_seen, e, out_data_o);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("watchdog expired, %0d results outstanding", setpoint_q.size());
      $display("landing_descent_profile_core_test failed");
      $finish;
    end
  end

  // rejected, inactive and time sync transactions straight after reset
  task automatic test_idle_rejects();
    send_item(make_item(REQ_UPDATE, 48'd100, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1));
    send_item(make_item(REQ_RSVD, 48'hFFFFFFFFFFFF, 1'b1, '1, '1, '1, 1'b1));
    send_item(make_item(REQ_SYNC, 48'hFFFFFFFFFFFF, 1'b0, '1, '1, '1, 1'b0));
    send_item(make_item(REQ_SYNC, 48'hFFFFFFFFFFFF, 1'b1, 32'h80000000, 32'h80000000,
                        32'h80000000, 1'b0));
    send_item(make_item(REQ_TAKEOVER, 48'd5, 1'b1, 32'd1, 32'd1, 32'd1, 1'b1));
    send_item(make_item(REQ_SYNC, 48'd0, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0));
  endtask

  // takeover extremes, error ordering, long gap, disarm failure
  task automatic test_directed_landing();
    send_item(make_item(REQ_TAKEOVER, 48'd1000, 1'b1, 32'h7FFFFFFF, 32'h80000000,
                        32'h7FFFFFFF, 1'b1));
    send_item(make_item(REQ_UPDATE, 48'd999, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1));
    send_item(make_item(REQ_UPDATE, 48'd2000, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1));
    send_item(make_item(REQ_UPDATE, 48'd70000, 1'b1, 32'd0, 32'd0, 32'h7FFFFFFF, 1'b0));
    send_item(make_item(REQ_UPDATE, 48'h00FF00000000, 1'b1, 32'd0, 32'd0,
                        32'h00100000, 1'b1));
    send_item(make_item(REQ_UPDATE, 48'h00FF00010000, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0));
    send_item(make_item(REQ_UPDATE, 48'h00FF00020000, 1'b1, 32'd0, 32'd0,
                        32'h80000000, 1'b1));
    send_item(make_item(REQ_UPDATE, 48'h00FF00030000, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1));
    send_item(make_item(REQ_TAKEOVER, 48'h7FFFFFFFFFFF, 1'b1, 32'd0, 32'd0,
                        32'h80000000, 1'b1));
    send_item(make_item(REQ_UPDATE, 48'hFFFFFFFFFFFF, 1'b1, 32'h12345678, 32'd0,
                        32'h80000000, 1'b1));
    send_item(make_item(REQ_SYNC, 48'd0, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1));
  endtask

  // one takeover and a descent with random content and some noise
  task automatic run_descent();
    logic [47:0] t;
    logic signed [31:0] z;
    int unsigned n;
    t = {1'b0, 15'($urandom_range(32'h7FFF, 0)), $urandom()};
    if ($urandom_range(9) == 0)
      send_item(make_item(REQ_SYNC, {16'($urandom_range(16'hFFFF, 0)), $urandom()},
                          1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                          1'b0));
    send_item(make_item(REQ_SYNC, t, 1'b1, $urandom(), $urandom(), $urandom(), 1'b0));
    z = ($urandom_range(7) == 0) ? $signed($urandom()) : $signed($urandom_range(32'h00A00000));
    send_item(make_item(REQ_TAKEOVER, t, $urandom_range(19) != 0, $urandom(), $urandom(),
                        z, 1'($urandom_range(1))));
    n = $urandom_range(30, 4);
    repeat (n) begin
      in_t it;
      if ($urandom_range(49) == 0) t += 48'({8'($urandom_range(8'hFF)), $urandom()});
      else t += 48'($urandom_range(20000));
      z -= $signed($urandom_range(32'h00060000));
      it = make_item(REQ_UPDATE, t, 1'b1, $urandom(), $urandom(), z,
                     $urandom_range(9) != 0);
      case ($urandom_range(19))
        0: it.req_type = req_e'($urandom_range(3));
        1: it.pose_valid = 1'b0;
        2: it.timestamp = t - 48'($urandom_range(1000, 1));
        default: ;
      endcase
      send_item(it);
    end
  endtask

  // random descents across idle phases and register settings
  task automatic test_random_descents();
    int unsigned phase;
    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      case (phase % 5)
        0: load_profile(-32'sd32768, -32'sd6554, -32'sd32768, 32'd65536, 32'sd6554);
        1: load_profile(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                        32'h7FFFFFFF);
        2: load_profile(32'd0, 32'd0, 32'hFFFFFFFF, 32'd1, 32'h80000000);
        3: load_profile(-$signed($urandom_range(32'h00040000)),
                        -$signed($urandom_range(32'h00010000)),
                        -$signed($urandom_range(32'h00040000, 1)),
                        $urandom_range(32'h00040000, 1), $urandom_range(32'h00020000));
        default: load_profile({1'b1, 31'($urandom_range(32'h7FFFFFFF))},
                              {1'b1, 31'($urandom_range(32'h7FFFFFFF))},
                              {1'b1, 31'($urandom_range(32'h7FFFFFFF))},
                              $urandom_range(32'h7FFFFFFF, 1), $urandom());
      endcase
      repeat (6) run_descent();
      if (phase % 7 == 3) drain_results();
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_rejects();
    test_directed_landing();
    test_random_descents();
    drain_results();
    $display("sent %0d transactions: %0d takeovers, %0d good updates, %0d landings",
             items_sent, takeovers, updates_ok, landings);
    $display("checked %0d results over four idle patterns and several register sets, %0d bad",
             results_seen, mismatches);
    if (mismatches == 0 && setpoint_q.size() == 0)
      $display("landing_descent_profile_core_test passed");
    else
      $display("landing_descent_profile_core_test failed");
    $finish;
  end

endmodule
